// ----- sv/rolling_loudness_range_core_macros.svh -----
// assertion helpers used by rlr_ctrl
`ifndef ROLLING_LOUDNESS_RANGE_CORE_MACROS_SVH
`define ROLLING_LOUDNESS_RANGE_CORE_MACROS_SVH

// condition that holds at every edge outside reset
`define RLR_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define RLR_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- sv/rlr_pkg.sv -----
`default_nettype none
package rlr_pkg;

  localparam logic OP_STORE     = 1'b0;
  localparam logic OP_RECOMPUTE = 1'b1;

  localparam logic signed [15:0] GATE_FLOOR = -16'sd8960;
  localparam logic [15:0] SIGN_FLIP = 16'h8000;
  localparam int MIN_GATED = 4;
  // reciprocal of 100 in 2^-19 steps, exact for the rank range used
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SHIFT = 19;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] second_index;
    logic signed [15:0] short_term;
    logic signed [15:0] gate_level;
  } in_t;

  typedef struct packed {
    logic [15:0] loudness_range;
    logic        computed;
    logic [6:0]  gated_count;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] tag;
    logic signed [15:0] gate;
    logic signed [15:0] loud;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic check;
    logic scan;
    logic select;
    logic radix;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic present;
    logic scan_done;
    logic enough;
    logic radix_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/rlr_ram.sv -----
`default_nettype none
module rlr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/rlr_ctrl.sv -----
`default_nettype none
`include "rolling_loudness_range_core_macros.svh"
module rlr_ctrl
  import rlr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SELECT = 3'd5;
  localparam logic [2:0] S_RADIX  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_LOOK;
      S_LOOK:   state_next = S_CHECK;
      S_CHECK:  state_next = sts.present ? S_SCAN : S_FINISH;
      S_SCAN:   if (sts.scan_done) state_next = S_SELECT;
      S_SELECT: state_next = sts.enough ? S_RADIX : S_FINISH;
      S_RADIX:  if (sts.radix_last) state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && start;
    cmd.lookup = (state == S_LOOK);
    cmd.check  = (state == S_CHECK);
    cmd.scan   = (state == S_SCAN);
    cmd.select = (state == S_SELECT);
    cmd.radix  = (state == S_RADIX);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);

  `RLR_NEXT(a_accept_looks, cmd.accept, state == S_LOOK, "request not followed by lookup")
  `RLR_NEXT(a_done_once, done, !done && state == S_IDLE, "result strobe longer than a cycle")
  `RLR_NEXT(a_absent_skips, cmd.check && !sts.present, done, "absent second not reported")
  `RLR_ALWAYS(a_one_cmd, $onehot0(cmd), "more than one datapath command")

endmodule
`default_nettype wire

// ----- sv/rlr_datapath.sv -----
`default_nettype none
module rlr_datapath
  import rlr_pkg::*;
#(
  parameter int SECOND_SLOTS = 4096,
  parameter int MAX_WINDOW   = 120
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  input  wire in_t        request,
  input  wire logic [6:0] window_seconds,
  output sts_t            sts,
  output out_t            result
);

  localparam int SB = $clog2(SECOND_SLOTS);
  localparam int VB = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);

  in_t                req;
  logic [SB-1:0]      clr_addr;
  logic signed [15:0] gate;
  logic [CW-1:0]      n_win, issue_k, cnt;
  logic               pipe_v, pipe_ok;
  logic [31:0]        pipe_t;
  logic               present_f, enough_f;
  logic [3:0]         bit_idx;
  logic [CW-1:0]      j, k_a, k_b, cnt_a, cnt_b;
  logic               rpipe;
  logic [15:0]        p_a, p_b;

  // slot store
  logic          s_we;
  logic [SB-1:0] s_waddr, s_raddr;
  slot_t         s_wdata, s_rdata;

  logic signed [32:0] t_next;
  assign t_next = {req.second_index[31], req.second_index} - 33'(issue_k);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = clr_addr;
    s_wdata = '0;
    if (cmd.clear) begin
      s_we = 1'b1;
    end else if (cmd.accept && request.operation == OP_STORE) begin
      s_we    = 1'b1;
      s_waddr = request.second_index[SB-1:0];
      s_wdata = '{valid: 1'b1, tag: request.second_index,
                  gate: request.gate_level, loud: request.short_term};
    end
    s_raddr = cmd.scan ? t_next[SB-1:0] : req.second_index[SB-1:0];
  end

  rlr_ram #(.WIDTH($bits(slot_t)), .DEPTH(SECOND_SLOTS)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // gated value buffer
  logic        v_we;
  logic [15:0] v_rdata;
  logic        hit;
  assign hit  = pipe_v && pipe_ok && s_rdata.valid && (s_rdata.tag == pipe_t)
              && (s_rdata.loud >= gate);
  assign v_we = cmd.scan && hit;

  rlr_ram #(.WIDTH(16), .DEPTH(MAX_WINDOW)) u_vals (
    .clk(clk), .we(v_we), .waddr(cnt[VB-1:0]), .wdata(s_rdata.loud),
    .raddr(j[VB-1:0]), .rdata(v_rdata)
  );

  // window length clamped to 1..MAX_WINDOW
  logic [CW-1:0] n_clamp;
  always_comb begin
    if (window_seconds == 7'd0) begin
      n_clamp = CW'(1);
    end else if (32'(window_seconds) > MAX_WINDOW) begin
      n_clamp = CW'(MAX_WINDOW);
    end else begin
      n_clamp = CW'(window_seconds);
    end
  end

  // ranks ceil(0.10c) and ceil(0.95c) by reciprocal multiply
  logic [11:0] x10;
  logic [14:0] x95;
  logic [23:0] m10;
  logic [26:0] m95;
  assign x10 = 12'(cnt) * 12'd10 + 12'd99;
  assign x95 = 15'(cnt) * 15'd95 + 15'd99;
  assign m10 = 24'(x10) * 24'(RECIP_100);
  assign m95 = 27'(x95) * 27'(RECIP_100);

  logic [15:0] u, hi_mask;
  logic        pass_done;
  assign u         = v_rdata ^ SIGN_FLIP;
  assign hi_mask   = 16'hFFFF << ({1'b0, bit_idx} + 5'd1);
  assign pass_done = (j == cnt) && !rpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pipe_v   <= 1'b0;
      rpipe    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + SB'(1);
      end
      if (cmd.accept) begin
        req <= request;
      end
      if (cmd.check) begin
        present_f <= s_rdata.valid && (s_rdata.tag == req.second_index);
        gate      <= (s_rdata.gate < GATE_FLOOR) ? GATE_FLOOR : s_rdata.gate;
        n_win     <= n_clamp;
        issue_k   <= '0;
        cnt       <= '0;
        pipe_v    <= 1'b0;
        enough_f  <= 1'b0;
      end
      if (cmd.scan) begin
        if (issue_k != n_win) begin
          issue_k <= issue_k + CW'(1);
          pipe_v  <= 1'b1;
          // seconds below the timeline never match
          pipe_ok <= (t_next[32] == t_next[31]);
          pipe_t  <= t_next[31:0];
        end else begin
          pipe_v <= 1'b0;
        end
        if (hit) begin
          cnt <= cnt + CW'(1);
        end
      end
      if (cmd.select) begin
        enough_f <= (32'(cnt) >= MIN_GATED);
        k_a      <= CW'(m10 >> RECIP_SHIFT);
        k_b      <= CW'(m95 >> RECIP_SHIFT);
        p_a      <= '0;
        p_b      <= '0;
        bit_idx  <= 4'd15;
        j        <= '0;
        cnt_a    <= '0;
        cnt_b    <= '0;
        rpipe    <= 1'b0;
      end
      if (cmd.radix) begin
        if (pass_done) begin
          if (k_a > cnt_a) begin
            p_a[bit_idx] <= 1'b1;
            k_a          <= k_a - cnt_a;
          end
          if (k_b > cnt_b) begin
            p_b[bit_idx] <= 1'b1;
            k_b          <= k_b - cnt_b;
          end
          bit_idx <= bit_idx - 4'd1;
          j       <= '0;
          cnt_a   <= '0;
          cnt_b   <= '0;
        end else begin
          if (j != cnt) begin
            j     <= j + CW'(1);
            rpipe <= 1'b1;
          end else begin
            rpipe <= 1'b0;
          end
          // count values sharing the prefix with a zero in the current bit
          if (rpipe) begin
            if (((u ^ p_a) & hi_mask) == 16'd0 && !u[bit_idx]) begin
              cnt_a <= cnt_a + CW'(1);
            end
            if (((u ^ p_b) & hi_mask) == 16'd0 && !u[bit_idx]) begin
              cnt_b <= cnt_b + CW'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    sts.clr_last   = (clr_addr == SB'(SECOND_SLOTS - 1));
    sts.present    = s_rdata.valid && (s_rdata.tag == req.second_index);
    sts.scan_done  = (issue_k == n_win) && !pipe_v;
    sts.enough     = (32'(cnt) >= MIN_GATED);
    sts.radix_last = pass_done && (bit_idx == 4'd0);
  end

  logic [16:0] diff;
  assign diff = {1'b0, p_b} - {1'b0, p_a};

  always_comb begin
    result.loudness_range = (present_f && enough_f && !diff[16]) ? diff[15:0] : 16'd0;
    result.computed       = present_f;
    result.gated_count    = present_f ? 7'(cnt) : 7'd0;
  end

endmodule
`default_nettype wire

// ----- sv/rolling_loudness_range_core.sv -----
// sequence: a present second is looked up, its window of n seconds scanned and its c gated values
// radix-selected; an absent second, or fewer than four gated values, goes straight to the result
// throughput: one request at a time, set by the slot scan and the 16-pass radix select
// reset: a clearing pass over all SECOND_SLOTS slots wipes the slot valid flags, busy stays high
// window_seconds resets to 60; results come on done for one cycle, no stall
`default_nettype none
module rolling_loudness_range_core
  import rlr_pkg::*;
#(
  parameter int SECOND_SLOTS = 4096,
  parameter int MAX_WINDOW   = 120
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        request,
  output logic            done,
  output out_t            result,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data
);

  logic [6:0] window_seconds;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= 7'd60;
    end else if (cfg_we) begin
      window_seconds <= cfg_data;
    end
  end

  rlr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts),
    .cmd(cmd), .busy(busy), .done(done)
  );

  rlr_datapath #(.SECOND_SLOTS(SECOND_SLOTS), .MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .request(request),
    .window_seconds(window_seconds), .sts(sts), .result(result)
  );

endmodule
`default_nettype wire

// ----- tb/rolling_loudness_range_core_tb.sv -----
`default_nettype none
module rolling_loudness_range_core_tb;
  import rlr_pkg::*;

  localparam int SLOTS = 4096;
  localparam int WMAX = 120;
  localparam int RANDOM_ITEMS = 540;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t request = '0;
  logic done;
  out_t result;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  rolling_loudness_range_core #(.SECOND_SLOTS(SLOTS), .MAX_WINDOW(WMAX)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [15:0] loud_mem [SLOTS];
  logic signed [15:0] gate_mem [SLOTS];
  logic signed [31:0] tag_mem [SLOTS];
  bit slot_live [SLOTS];
  logic [6:0] window_reg;

  typedef struct {
    in_t r;
    bit has_fixed;
    out_t fixed;
  } row_t;

  row_t rows [$];
  out_t range_queue [$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int computed_seen = 0;
  int full_seen = 0;

  function automatic int slot_of(longint sec);
    longint m;
    m = sec % SLOTS;
    if (m < 0) m += SLOTS;
    return int'(m);
  endfunction

  function automatic out_t predict_range(in_t r);
    out_t o;
    int s, n, g, c, j, i10, i95, d;
    longint sec, t;
    int vals [WMAX];
    o = '0;
    sec = longint'(r.second_index);
    s = slot_of(sec);
    if (r.operation == OP_STORE) begin
      loud_mem[s] = r.short_term;
      gate_mem[s] = r.gate_level;
      tag_mem[s] = r.second_index;
      slot_live[s] = 1'b1;
    end
    if (!(slot_live[s] && longint'(tag_mem[s]) == sec)) return o;
    n = int'(window_reg);
    if (n < 1) n = 1;
    if (n > WMAX) n = WMAX;
    g = int'(gate_mem[s]);
    if (g < int'(GATE_FLOOR)) g = int'(GATE_FLOOR);
    c = 0;
    for (int k = 0; k < n; k++) begin
      t = sec - k;
      if (t < -64'sd2147483648) break;
      s = slot_of(t);
      if (!(slot_live[s] && longint'(tag_mem[s]) == t)) continue;
      if (int'(loud_mem[s]) >= g) begin
        j = c;
        while (j > 0 && vals[j-1] > int'(loud_mem[s])) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = int'(loud_mem[s]);
        c++;
      end
    end
    if (c >= MIN_GATED) begin
      i10 = (c * 10 + 99) / 100 - 1;
      i95 = (c * 95 + 99) / 100 - 1;
      if (i10 < 0) i10 = 0;
      if (i95 > c - 1) i95 = c - 1;
      d = vals[i95] - vals[i10];
      o.loudness_range = d > 0 ? 16'(d) : 16'd0;
    end
    o.computed = 1'b1;
    o.gated_count = 7'(c);
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      results_seen++;
      if (range_queue.size() == 0) begin
        $error("result with no request pending: %p", result);
        errors++;
      end else begin
        want = range_queue.pop_front();
        if (result.computed) computed_seen++;
        if (result.gated_count >= 4) full_seen++;
        if (result.loudness_range !== want.loudness_range) begin
          $error("loudness_range expected %0d got %0d", want.loudness_range,
                 result.loudness_range);
          errors++;
        end
        if (result.computed !== want.computed) begin
          $error("computed expected %0d got %0d", want.computed, result.computed);
          errors++;
        end
        if (result.gated_count !== want.gated_count) begin
          $error("gated_count expected %0d got %0d", want.gated_count,
                 result.gated_count);
          errors++;
        end
      end
    end
  end

  task automatic send(in_t r, bit has_fixed, out_t fixed);
    out_t p;
    request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    p = predict_range(r);
    if (has_fixed && p !== fixed) begin
      $error("directed row expected %p predictor %p", fixed, p);
      errors++;
    end
    range_queue.insert(range_queue.size(), p);
    accepted++;
    start <= 1'b0;
    // send has already waited for the block to return to idle
    @(posedge clk);
  endtask

  task automatic drain();
    while (range_queue.size() != 0) @(posedge clk);
    // let the block settle back to idle
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(logic [6:0] w);
    cfg_data <= w;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = w;
  endtask

  function automatic in_t mk(logic op, int sec, int lt, int gt);
    in_t r;
    r.operation = op;
    r.second_index = sec;
    r.short_term = 16'(lt);
    r.gate_level = 16'(gt);
    return r;
  endfunction

  function automatic out_t res(int rng, bit comp, int cnt);
    out_t o;
    o.loudness_range = 16'(rng);
    o.computed = comp;
    o.gated_count = 7'(cnt);
    return o;
  endfunction

  function automatic void add_row(in_t r, bit hf, out_t f);
    row_t x;
    x.r = r;
    x.has_fixed = hf;
    x.fixed = f;
    rows.insert(rows.size(), x);
  endfunction

  task automatic random_item(int base, int spread);
    in_t r;
    int sec;
    sec = base + $urandom_range(0, spread);
    r.operation = ($urandom_range(0, 5) == 0) ? OP_RECOMPUTE : OP_STORE;
    r.second_index = sec;
    case ($urandom_range(0, 7))
      0: r.short_term = 16'($urandom);
      default: r.short_term = 16'(-3000 - int'($urandom_range(0, 4000)));
    endcase
    case ($urandom_range(0, 5))
      0: r.gate_level = 16'($urandom);
      1: r.gate_level = 16'sh8000;
      default: r.gate_level = 16'(-6000 - int'($urandom_range(0, 4000)));
    endcase
    send(r, 1'b0, '0);
  endtask

  initial begin
    int burst, base;
    window_reg = 7'd60;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    add_row(mk(OP_RECOMPUTE, 5, 0, 0), 1, res(0, 0, 0));
    add_row(mk(OP_STORE, 100, -2560, -32768), 1, res(0, 1, 1));
    add_row(mk(OP_STORE, 101, -2000, -32768), 1, res(0, 1, 2));
    add_row(mk(OP_STORE, 102, -9000, -32768), 1, res(0, 1, 2));
    add_row(mk(OP_STORE, 103, 32767, -32768), 1, res(0, 1, 3));
    add_row(mk(OP_STORE, 104, -8960, -32768), 0, '0);
    add_row(mk(OP_STORE, 105, 100, 32767), 1, res(0, 1, 1));
    add_row(mk(OP_RECOMPUTE, 104, 0, 0), 0, '0);
    add_row(mk(OP_RECOMPUTE, 104 + SLOTS, 0, 0), 1, res(0, 0, 0));
    add_row(mk(OP_STORE, 32'sh80000000, -32768, -32768), 1, res(0, 1, 0));
    add_row(mk(OP_STORE, 32'sh80000001, -1000, -32768), 1, res(0, 1, 1));
    add_row(mk(OP_STORE, 32'sh7fffffff, -1000, 0), 1, res(0, 1, 0));
    add_row(mk(OP_STORE, -1, -4000, -9000), 1, res(0, 1, 1));
    add_row(mk(OP_STORE, 0, -3000, -9000), 1, res(0, 1, 2));
    add_row(mk(OP_STORE, 1, -2000, -9000), 1, res(0, 1, 3));
    add_row(mk(OP_STORE, 2, -1000, -9000), 0, '0);
    add_row(mk(OP_STORE, 2 - SLOTS, -1000, -9000), 0, '0);
    add_row(mk(OP_RECOMPUTE, 2, 0, 0), 1, res(0, 0, 0));
    foreach (rows[i]) send(rows[i].r, rows[i].has_fixed, rows[i].fixed);
    drain();

    // window settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_window(7'd0);
        1: write_window(7'd127);
        2: write_window(7'd120);
        3: write_window(7'd1);
        4: write_window(7'd7);
        default: write_window(7'($urandom_range(2, 127)));
      endcase
      base = (ph == 5) ? int'($urandom) : 1000 * ph - 20000;
      for (int n = 0; n < RANDOM_ITEMS / 6; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < RANDOM_ITEMS / 6; b++, n++)
          random_item(base + n, 8);
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      // a few recomputes and one far-off store to hit stale tags
      for (int n = 0; n < 4; n++)
        send(mk(OP_RECOMPUTE, base + $urandom_range(0, 100), $urandom, $urandom), 0, '0);
      send(mk(OP_STORE, base + SLOTS + 3, $urandom, $urandom), 0, '0);
      drain();
    end

    $display("run covered %0d requests, %0d results, %0d computed, %0d with four or more",
             accepted, results_seen, computed_seen, full_seen);
    $display("window register swept through zero, one, 7, 120, 127 and a random value");
    if (errors == 0 && range_queue.size() == 0) begin
      $display("PASS rolling_loudness_range_core");
    end else begin
      $display("FAIL rolling_loudness_range_core");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("FAIL rolling_loudness_range_core");
    $finish;
  end

endmodule
`default_nettype wire
